FILE: hdl/event_flag_group_with_waiters_defines.svh
// Assertion macros for the event flag group block.
// Used by the core and the output stage; expects aclk and aresetn in scope.
`ifndef EVENT_FLAG_GROUP_WITH_WAITERS_DEFINES_SVH
`define EVENT_FLAG_GROUP_WITH_WAITERS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EFG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EFG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/efg_pkg.sv
// Shared types, codes and helpers for the event flag group block.
// No dependencies; used by every module under hdl except efg_ram.
package efg_pkg;

    localparam int WAITER_SLOTS = 16;
    localparam int SLOT_W       = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int FLAG_W       = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // item kinds
    localparam logic [2:0] KIND_SET    = 3'd0;
    localparam logic [2:0] KIND_CLEAR  = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_WAIT   = 3'd3;
    localparam logic [2:0] KIND_CANCEL = 3'd4;

    // result status codes
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_INVALID     = 3'd1;
    localparam logic [2:0] STATUS_WOULD_BLOCK = 3'd2;
    localparam logic [2:0] STATUS_PARKED      = 3'd3;
    localparam logic [2:0] STATUS_WOKEN       = 3'd4;
    localparam logic [2:0] STATUS_CANCELLED   = 3'd5;
    localparam logic [2:0] STATUS_NOT_PARKED  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CLEAR = 1'd1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [FLAG_W-1:0] flag_bits;
        logic [FLAG_W-1:0] want_mask;
        logic [3:0]        waiter_slot;
        logic              may_park;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [FLAG_W-1:0] flags_now;
        logic [FLAG_W-1:0] got_bits;
        logic [3:0]        woken_slot;
        logic              last;
    } res_item_t;

    // result handed from the core to the output stage
    typedef struct packed {
        logic      load;
        res_item_t res;
    } res_beat_t;

    // mask RAM access from the core
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [FLAG_W-1:0] wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_FINAL
    } fsm_state_t;

    // any-bit match in mode 0, all-bits match in mode 1
    function automatic logic mask_met(input logic [FLAG_W-1:0] flags,
                                      input logic [FLAG_W-1:0] mask,
                                      input logic              mode);
        logic [FLAG_W-1:0] hit;
        hit = flags & mask;
        return mode ? (hit == mask) : (hit != '0);
    endfunction

endpackage

FILE: hdl/efg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module efg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/efg_outreg.sv
// Output register stage for result beats; decouples the core from m_ready.
// Depends on efg_pkg and the assertion macro header.
`include "event_flag_group_with_waiters_defines.svh"

module efg_outreg (
    input  logic              aclk,
    input  logic              aresetn,
    input  efg_pkg::res_beat_t beat,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output efg_pkg::res_item_t m_payload
);

    logic               valid_reg;
    logic               valid_next;
    efg_pkg::res_item_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (beat.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat.load) begin
            data_reg <= beat.res;
        end
    end

    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

    `EFG_ASSERT_NOW(a_load_only_when_free, beat.load, !valid_reg || m_ready, "beat loaded over a held result")

endmodule

FILE: hdl/efg_core.sv
// Control core: flag word, parked bits, configuration, item decode and wake scan.
// Depends on efg_pkg and the assertion macro header; drives the mask RAM.
`include "event_flag_group_with_waiters_defines.svh"

module efg_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  efg_pkg::in_item_t                   s_payload,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [efg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [efg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output efg_pkg::ram_req_t                   ram_req,
    input  logic [efg_pkg::FLAG_W-1:0]          ram_rd_data,
    output efg_pkg::res_beat_t                  beat,
    input  logic                                can_load
);

    efg_pkg::fsm_state_t                 state_reg, state_next;
    logic [efg_pkg::FLAG_W-1:0]          flag_reg, flag_next;
    logic [efg_pkg::WAITER_SLOTS-1:0]    parked_reg, parked_next;
    logic [efg_pkg::SLOT_W-1:0]          idx_reg, idx_next;
    logic                                mode_reg, auto_clear_reg;

    logic                                accept;
    logic                                slot_ok;
    logic [efg_pkg::SLOT_W-1:0]          slot_idx;
    logic                                slot_busy;
    logic                                idx_last;
    logic                                scan_met;
    logic [efg_pkg::FLAG_W-1:0]          set_word;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == efg_pkg::ST_IDLE) && can_load;
    assign accept    = s_valid && s_ready;

    assign slot_ok   = 32'(s_payload.waiter_slot) < 32'(efg_pkg::WAITER_SLOTS);
    assign slot_idx  = efg_pkg::SLOT_W'(s_payload.waiter_slot);
    assign slot_busy = slot_ok && parked_reg[slot_idx];
    assign idx_last  = idx_reg == efg_pkg::SLOT_W'(efg_pkg::WAITER_SLOTS - 1);
    assign scan_met  = efg_pkg::mask_met(flag_reg, ram_rd_data, mode_reg);
    assign set_word  = mode_reg ? s_payload.flag_bits : (flag_reg | s_payload.flag_bits);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            efg_pkg::ST_IDLE: begin
                if (accept && s_payload.kind == efg_pkg::KIND_SET) begin
                    state_next = efg_pkg::ST_SCAN;
                end
            end
            efg_pkg::ST_SCAN: begin
                if (parked_reg[idx_reg]) begin
                    state_next = efg_pkg::ST_EVAL;
                end else if (idx_last) begin
                    state_next = efg_pkg::ST_FINAL;
                end
            end
            efg_pkg::ST_EVAL: begin
                if (!scan_met || can_load) begin
                    state_next = idx_last ? efg_pkg::ST_FINAL : efg_pkg::ST_SCAN;
                end
            end
            efg_pkg::ST_FINAL: begin
                if (can_load) begin
                    state_next = efg_pkg::ST_IDLE;
                end
            end
            default: state_next = efg_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        flag_next   = flag_reg;
        parked_next = parked_reg;
        idx_next    = idx_reg;
        ram_req     = '0;
        beat        = '0;
        beat.res.last = 1'b1;

        unique case (state_reg)
            efg_pkg::ST_IDLE: begin
                if (accept) begin
                    beat.load       = s_payload.kind != efg_pkg::KIND_SET;
                    beat.res.status = efg_pkg::STATUS_OK;
                    unique case (s_payload.kind)
                        efg_pkg::KIND_SET: begin
                            flag_next = set_word;
                            idx_next  = '0;
                        end
                        efg_pkg::KIND_CLEAR: begin
                            flag_next = flag_reg & ~s_payload.flag_bits;
                        end
                        efg_pkg::KIND_READ: begin
                        end
                        efg_pkg::KIND_WAIT: begin
                            if (s_payload.want_mask == '0) begin
                                beat.res.status = efg_pkg::STATUS_INVALID;
                            end else if (efg_pkg::mask_met(flag_reg, s_payload.want_mask,
                                                           mode_reg)) begin
                                beat.res.got_bits = flag_reg & s_payload.want_mask;
                                if (auto_clear_reg) begin
                                    flag_next = flag_reg & ~s_payload.want_mask;
                                end
                            end else if (!s_payload.may_park) begin
                                beat.res.status = efg_pkg::STATUS_WOULD_BLOCK;
                            end else if (!slot_ok || slot_busy) begin
                                beat.res.status = efg_pkg::STATUS_INVALID;
                            end else begin
                                beat.res.status       = efg_pkg::STATUS_PARKED;
                                parked_next[slot_idx] = 1'b1;
                                ram_req.wr_en         = 1'b1;
                                ram_req.wr_addr       = slot_idx;
                                ram_req.wr_data       = s_payload.want_mask;
                            end
                        end
                        efg_pkg::KIND_CANCEL: begin
                            if (slot_busy) begin
                                beat.res.status       = efg_pkg::STATUS_CANCELLED;
                                beat.res.woken_slot   = s_payload.waiter_slot;
                                parked_next[slot_idx] = 1'b0;
                            end else begin
                                beat.res.status = efg_pkg::STATUS_NOT_PARKED;
                            end
                        end
                        default: begin
                            beat.res.status = efg_pkg::STATUS_INVALID;
                        end
                    endcase
                end
            end
            efg_pkg::ST_SCAN: begin
                // fetch the mask only for a parked slot; skip free slots
                ram_req.rd_en   = parked_reg[idx_reg];
                ram_req.rd_addr = idx_reg;
                if (!parked_reg[idx_reg] && !idx_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            efg_pkg::ST_EVAL: begin
                if (scan_met && can_load) begin
                    beat.load           = 1'b1;
                    beat.res.status     = efg_pkg::STATUS_WOKEN;
                    beat.res.woken_slot = 4'(idx_reg);
                    beat.res.last       = 1'b0;
                    parked_next[idx_reg] = 1'b0;
                end
                if ((!scan_met || can_load) && !idx_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            efg_pkg::ST_FINAL: begin
                beat.load       = can_load;
                beat.res.status = efg_pkg::STATUS_OK;
            end
            default: begin
            end
        endcase

        beat.res.flags_now = flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= efg_pkg::ST_IDLE;
            flag_reg       <= '0;
            parked_reg     <= '0;
            idx_reg        <= '0;
            mode_reg       <= 1'b0;
            auto_clear_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            flag_reg   <= flag_next;
            parked_reg <= parked_next;
            idx_reg    <= idx_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    efg_pkg::CFG_GROUP_MODE: mode_reg       <= cfg_wdata[0];
                    efg_pkg::CFG_AUTO_CLEAR: auto_clear_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `EFG_ASSERT_NXT(a_set_starts_scan, accept && s_payload.kind == efg_pkg::KIND_SET, state_reg == efg_pkg::ST_SCAN && idx_reg == '0, "set did not start the scan at slot zero")
    `EFG_ASSERT_NOW(a_eval_on_parked, state_reg == efg_pkg::ST_EVAL, parked_reg[idx_reg], "mask evaluated for a free slot")
    `EFG_ASSERT_NXT(a_wake_frees_slot, beat.load && beat.res.status == efg_pkg::STATUS_WOKEN, !parked_reg[$past(idx_reg)], "woken slot still parked")
    `EFG_ASSERT_NOW(a_last_only_at_end, beat.load && !beat.res.last, state_reg == efg_pkg::ST_EVAL, "non-final beat outside the wake scan")

endmodule

FILE: hdl/event_flag_group_with_waiters.sv
// Event flag group with parked waiters: 32-bit flag word, waiter slots with wait masks.
// Every item except set gives one result beat, which shows on the output register the
// cycle after the item is taken. A set walks all WAITER_SLOTS slots through the mask
// RAM, skipping free slots and, for each parked slot, reading its mask and then comparing
// it against the new word. It emits one woken beat for each satisfied waiter in slot
// order and a closing ok beat with last set, and the walk waits on any m_ready stall.
// The mask RAM's single read port sets the scan pace. Configuration writes are taken at
// any time but must only be issued while no item is in flight. Masks in the RAM need no
// clearing after reset; only parked slots are read.
module event_flag_group_with_waiters (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  efg_pkg::in_item_t              s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output efg_pkg::res_item_t             m_payload,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [efg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    efg_pkg::ram_req_t          ram_req;
    logic [efg_pkg::FLAG_W-1:0] ram_rd_data;
    efg_pkg::res_beat_t         beat;
    logic                       can_load;

    efg_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .beat        (beat),
        .can_load    (can_load)
    );

    efg_ram #(
        .WIDTH (efg_pkg::FLAG_W),
        .DEPTH (efg_pkg::WAITER_SLOTS)
    ) u_mask_ram (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    efg_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat      (beat),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

FILE: sim/tb_top.sv
// Testbench for event_flag_group_with_waiters: directed and random flag, wait and cancel beats.
// Needs efg_pkg and the block's RTL. An inline model of the flag word and waiter table
// predicts every result beat.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_IDLE     = 18;
    localparam int TAIL_CYCLES  = 60;
    localparam logic [2:0] KIND_FIRST_UNKNOWN = efg_pkg::KIND_CANCEL + 3'd1;
    localparam logic [efg_pkg::FLAG_W-1:0] ALL_ONES = '1;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    efg_pkg::in_item_t              s_payload = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    efg_pkg::res_item_t             m_payload;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [efg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [efg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // mirror of the block's state and registers
    logic [efg_pkg::FLAG_W-1:0]       flag_word       = '0;
    logic [efg_pkg::WAITER_SLOTS-1:0] slot_busy       = '0;
    logic [efg_pkg::FLAG_W-1:0]       slot_want [efg_pkg::WAITER_SLOTS];
    logic                             mode_all        = 1'b0;
    logic                             consume_on_wait = 1'b1;

    efg_pkg::res_item_t         due_beats [$];
    int                         fail_count  = 0;
    int                         cycle_count = 0;
    int                         items_sent  = 0;
    bit                         steady      = 1'b0;
    logic [efg_pkg::FLAG_W-1:0] bit_pool    = ALL_ONES;

    event_flag_group_with_waiters u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic efg_pkg::res_item_t flag_beat(logic [2:0] status,
                                                     logic [efg_pkg::FLAG_W-1:0] got,
                                                     logic [3:0] slot, logic last);
        efg_pkg::res_item_t r;
        r.status     = status;
        r.flags_now  = flag_word;
        r.got_bits   = got;
        r.woken_slot = slot;
        r.last       = last;
        return r;
    endfunction

    function automatic logic mask_hit(logic [efg_pkg::FLAG_W-1:0] mask);
        if (mode_all)
            return (flag_word & mask) == mask;
        return (flag_word & mask) != '0;
    endfunction

    function automatic void step_flag_group(efg_pkg::in_item_t it);
        logic [efg_pkg::FLAG_W-1:0] got;
        case (it.kind)
            efg_pkg::KIND_SET: begin
                flag_word = mode_all ? it.flag_bits : (flag_word | it.flag_bits);
                // wake in slot order, no bits consumed
                for (int i = 0; i < efg_pkg::WAITER_SLOTS; i++) begin
                    if (slot_busy[i] && mask_hit(slot_want[i])) begin
                        slot_busy[i] = 1'b0;
                        due_beats.push_back(flag_beat(efg_pkg::STATUS_WOKEN, '0, 4'(i), 1'b0));
                    end
                end
                due_beats.push_back(flag_beat(efg_pkg::STATUS_OK, '0, '0, 1'b1));
            end
            efg_pkg::KIND_CLEAR: begin
                flag_word = flag_word & ~it.flag_bits;
                due_beats.push_back(flag_beat(efg_pkg::STATUS_OK, '0, '0, 1'b1));
            end
            efg_pkg::KIND_READ: begin
                due_beats.push_back(flag_beat(efg_pkg::STATUS_OK, '0, '0, 1'b1));
            end
            efg_pkg::KIND_WAIT: begin
                if (it.want_mask == '0) begin
                    due_beats.push_back(flag_beat(efg_pkg::STATUS_INVALID, '0, '0, 1'b1));
                end else if (mask_hit(it.want_mask)) begin
                    got = flag_word & it.want_mask;
                    if (consume_on_wait)
                        flag_word = flag_word & ~it.want_mask;
                    due_beats.push_back(flag_beat(efg_pkg::STATUS_OK, got, '0, 1'b1));
                end else if (!it.may_park) begin
                    due_beats.push_back(flag_beat(efg_pkg::STATUS_WOULD_BLOCK, '0, '0, 1'b1));
                end else if (it.waiter_slot >= efg_pkg::WAITER_SLOTS
                             || slot_busy[it.waiter_slot]) begin
                    due_beats.push_back(flag_beat(efg_pkg::STATUS_INVALID, '0, '0, 1'b1));
                end else begin
                    slot_busy[it.waiter_slot] = 1'b1;
                    slot_want[it.waiter_slot] = it.want_mask;
                    due_beats.push_back(flag_beat(efg_pkg::STATUS_PARKED, '0, '0, 1'b1));
                end
            end
            efg_pkg::KIND_CANCEL: begin
                if (it.waiter_slot < efg_pkg::WAITER_SLOTS && slot_busy[it.waiter_slot]) begin
                    slot_busy[it.waiter_slot] = 1'b0;
                    due_beats.push_back(flag_beat(efg_pkg::STATUS_CANCELLED, '0,
                                                  it.waiter_slot, 1'b1));
                end else begin
                    due_beats.push_back(flag_beat(efg_pkg::STATUS_NOT_PARKED, '0, '0, 1'b1));
                end
            end
            default: begin
                due_beats.push_back(flag_beat(efg_pkg::STATUS_INVALID, '0, '0, 1'b1));
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s expected 0x%0h got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic void check_beat(efg_pkg::res_item_t act);
        efg_pkg::res_item_t exp_b;
        if (due_beats.size() == 0) begin
            $error("result beat with nothing outstanding, status %0d", act.status);
            fail_count++;
            return;
        end
        exp_b = due_beats.pop_front();
        compare_field("status", 32'(exp_b.status), 32'(act.status));
        compare_field("flags_now", exp_b.flags_now, act.flags_now);
        compare_field("got_bits", exp_b.got_bits, act.got_bits);
        compare_field("woken_slot", 32'(exp_b.woken_slot), 32'(act.woken_slot));
        compare_field("last", 32'(exp_b.last), 32'(act.last));
    endfunction

    // register writes first, then the input beat, then the result beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    efg_pkg::CFG_GROUP_MODE: mode_all = cfg_wdata[0];
                    efg_pkg::CFG_AUTO_CLEAR: consume_on_wait = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                step_flag_group(s_payload);
            if (m_valid && m_ready)
                check_beat(m_payload);
        end
    end

    initial begin : result_sink
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid && m_ready));
        end
    end

    task automatic send_item(efg_pkg::in_item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // drop valid and hold until every predicted beat has been checked
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [efg_pkg::CFG_IDX_W-1:0] idx, logic value);
        logic [efg_pkg::CFG_DATA_W-1:0] data;
        data    = $urandom();
        data[0] = value;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic mode, logic clr);
        wait_idle();
        write_reg(efg_pkg::CFG_GROUP_MODE, mode);
        write_reg(efg_pkg::CFG_AUTO_CLEAR, clr);
    endtask

    // unused fields carry junk, the block must ignore them
    function automatic efg_pkg::in_item_t junk_item(logic [2:0] kind);
        efg_pkg::in_item_t it;
        it.kind        = kind;
        it.flag_bits   = $urandom();
        it.want_mask   = $urandom();
        it.waiter_slot = 4'($urandom_range(0, 15));
        it.may_park    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic do_set(logic [efg_pkg::FLAG_W-1:0] bits);
        efg_pkg::in_item_t it;
        it = junk_item(efg_pkg::KIND_SET);
        it.flag_bits = bits;
        send_item(it);
    endtask

    task automatic do_clear(logic [efg_pkg::FLAG_W-1:0] bits);
        efg_pkg::in_item_t it;
        it = junk_item(efg_pkg::KIND_CLEAR);
        it.flag_bits = bits;
        send_item(it);
    endtask

    task automatic do_read();
        send_item(junk_item(efg_pkg::KIND_READ));
    endtask

    task automatic do_wait(logic [efg_pkg::FLAG_W-1:0] want, logic [3:0] slot, logic park);
        efg_pkg::in_item_t it;
        it = junk_item(efg_pkg::KIND_WAIT);
        it.want_mask   = want;
        it.waiter_slot = slot;
        it.may_park    = park;
        send_item(it);
    endtask

    task automatic do_cancel(logic [3:0] slot);
        efg_pkg::in_item_t it;
        it = junk_item(efg_pkg::KIND_CANCEL);
        it.waiter_slot = slot;
        send_item(it);
    endtask

    // nonzero subset of the phase's bit pool, sparse when asked
    function automatic logic [efg_pkg::FLAG_W-1:0] pick_bits(bit sparse);
        logic [efg_pkg::FLAG_W-1:0] w;
        w = bit_pool & $urandom();
        if (sparse)
            w = w & $urandom();
        if (w == '0)
            w = bit_pool & (~bit_pool + 1'b1);
        return w;
    endfunction

    task automatic test_basic_ops();
        logic [2:0] k;
        do_read();
        do_wait(32'h0000_0001, 4'd0, 1'b0);
        do_wait('0, 4'd0, 1'b1);
        do_set(ALL_ONES);
        do_wait(32'h8000_0001, 4'd9, 1'b0);
        do_clear(32'h0000_FFFF);
        do_wait(32'h0000_0001, 4'd0, 1'b1);
        do_wait(32'h8000_0000, 4'd15, 1'b1);
        do_wait(32'h0000_0001, 4'd0, 1'b1);
        do_cancel(4'd15);
        do_cancel(4'd15);
        do_cancel(4'd7);
        do_set(32'h0000_0001);
        do_set('0);
        do_clear(ALL_ONES);
        k = KIND_FIRST_UNKNOWN;
        repeat (3) begin
            send_item(junk_item(k));
            k = k + 3'd1;
        end
    endtask

    task automatic test_wait_modes();
        set_config(1'b0, 1'b0);
        do_set(32'h0000_00F0);
        do_wait(32'h0000_0010, 4'd2, 1'b0);
        set_config(1'b1, 1'b1);
        do_set(32'h0000_00FF);
        do_wait(32'h0000_01FF, 4'd3, 1'b1);
        do_wait(32'h0000_0003, 4'd4, 1'b1);
        do_set(32'h0000_01FF);
        do_wait(ALL_ONES, 4'd5, 1'b0);
        set_config(1'b1, 1'b0);
        do_set(ALL_ONES);
        do_wait(ALL_ONES, 4'd6, 1'b1);
    endtask

    // park every slot, then wake all of them with one set
    task automatic test_full_table();
        set_config(1'b0, 1'b1);
        do_clear(ALL_ONES);
        wait_idle();
        for (int i = 0; i < efg_pkg::WAITER_SLOTS; i++) begin
            if (slot_busy[i])
                do_cancel(4'(i));
        end
        for (int i = 0; i < efg_pkg::WAITER_SLOTS; i++)
            do_wait(32'h1 << i, 4'(i), 1'b1);
        do_set(ALL_ONES);
    endtask

    task automatic test_random_traffic();
        logic [1:0] setting [4];
        int         target;
        int         n;
        setting[0] = 2'b01;
        setting[1] = 2'b10;
        setting[2] = 2'b00;
        setting[3] = 2'b11;
        for (int p = 0; p < 4; p++) begin
            set_config(setting[p][1], setting[p][0]);
            bit_pool = ($urandom() & $urandom()) | (32'h1 << $urandom_range(0, 31));
            target   = items_sent + 14;
            while (items_sent < target) begin
                steady = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    6, 7: begin
                        send_item(junk_item(3'($urandom_range(0, 7))));
                    end
                    8: begin
                        do_wait(pick_bits(1'b0), 4'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)));
                    end
                    9: begin
                        wait_idle();
                        do_read();
                    end
                    default: begin
                        n = $urandom_range(1, 6);
                        if ($urandom_range(0, 1) == 0)
                            do_clear(bit_pool);
                        repeat (n)
                            do_wait(pick_bits(1'b1), 4'($urandom_range(0, 15)), 1'b1);
                        if ($urandom_range(0, 2) == 0)
                            do_cancel(4'($urandom_range(0, 15)));
                        do_set(pick_bits(1'b0));
                        if ($urandom_range(0, 1) == 0)
                            do_wait(pick_bits(1'b1), 4'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 1)));
                    end
                endcase
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_ops();
        test_wait_modes();
        test_full_table();
        test_random_traffic();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (due_beats.size() != 0) begin
            $error("%0d result beats never arrived", due_beats.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/efg_pkg.sv
hdl/efg_ram.sv
hdl/efg_outreg.sv
hdl/efg_core.sv
hdl/event_flag_group_with_waiters.sv
sim/tb_top.sv
